// File: src/sobel_gradient_3x3_macros.svh
// Assertion macros shared by the Sobel gradient RTL.
// Depends on a clk and an active-low rst_n being visible where a macro is used.
`ifndef SOBEL_GRADIENT_3X3_MACROS_SVH
`define SOBEL_GRADIENT_3X3_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SG3_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SG3_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sg3_pkg.sv
// Shared constants, types and helper functions of the Sobel gradient block.
// No dependencies; imported by the line store, window, queue and top-level files.
`timescale 1ns / 1ps

package sg3_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int PIX_W       = 8;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int GRAD_W      = PIX_W + 3;
    localparam int LINE_W      = 2 * PIX_W;
    localparam int S_TDATA_W   = ((PIX_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * GRAD_W + 7) / 8) * 8;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int FILL_W      = FIFO_CNT_W + 1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } sg3_cfg_idx_t;

    typedef logic [PIX_W-1:0] sg3_pix_t;

    // win[row][col], row 0 is the top row, col 0 the leftmost column
    typedef logic [2:0][2:0][PIX_W-1:0] sg3_win_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } sg3_grad_t;

    typedef struct packed {
        sg3_grad_t grad;
        logic      frame_end;
        logic      run_end;
    } sg3_res_t;

    // Per-item control carried from the input register into the window stage
    typedef struct packed {
        logic cmd;
        logic col_zero;
        logic last;
        logic active;
        logic row0;
    } sg3_ctl_t;

    // What the gradient stage pushes for one item
    typedef struct packed {
        logic emit_a;
        logic emit_b;
        logic frame_end;
    } sg3_emit_t;

    // Move every row one column left, keep the right column.
    function automatic sg3_win_t sg3_shift(input sg3_win_t win);
        sg3_win_t res;
        int r;
        res = win;
        for (r = 0; r < 3; r++)
        begin
            res[r][0] = win[r][1];
            res[r][1] = win[r][2];
        end
        return res;
    endfunction

    function automatic sg3_grad_t sg3_gradient(input sg3_win_t win);
        logic signed [GRAD_W-1:0] a [3][3];
        sg3_grad_t g;
        int r;
        int c;
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < 3; c++)
            begin
                a[r][c] = signed'({{(GRAD_W-PIX_W){1'b0}}, win[r][c]});
            end
        end
        g.gx = (a[0][2] - a[0][0]) + ((a[1][2] - a[1][0]) <<< 1) + (a[2][2] - a[2][0]);
        g.gy = (a[2][0] - a[0][0]) + ((a[2][1] - a[0][1]) <<< 1) + (a[2][2] - a[0][2]);
        return g;
    endfunction

endpackage

// File: src/sg3_line_store.sv
// Two-row line store: one word per column holds {upper row, middle row}.
// Depends on sg3_pkg; single write port, single registered read port.
`timescale 1ns / 1ps

module sg3_line_store
    import sg3_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [LINE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [LINE_W-1:0] rd_data
);

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-first: a same-cycle write is forwarded by the caller
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/sg3_window.sv
// 3x3 pixel window with edge replication and the two Sobel gradient taps.
// Depends on sg3_pkg for the window type, shift and gradient functions.
`timescale 1ns / 1ps

module sg3_window
    import sg3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      col_zero,
    input  logic      double_shift,
    input  sg3_pix_t  top,
    input  sg3_pix_t  mid,
    input  sg3_pix_t  bot,
    output sg3_grad_t grad_a,
    output sg3_grad_t grad_b
);

    // snap_reg is the window as first seen by the last item; dbl_reg says
    // the persistent window is that snapshot shifted once more
    sg3_win_t snap_reg;
    sg3_win_t snap_next;
    logic     dbl_reg;
    logic     dbl_next;
    sg3_win_t cur;
    sg3_win_t shifted;
    int       r;

    always_comb
    begin
        cur       = dbl_reg ? sg3_shift(snap_reg) : snap_reg;
        shifted   = sg3_shift(cur);
        snap_next = snap_reg;
        dbl_next  = dbl_reg;
        if (advance)
        begin
            for (r = 0; r < 3; r++)
            begin
                shifted[r][2] = (r == 0) ? top : ((r == 1) ? mid : bot);
            end
            if (col_zero)
            begin
                snap_next[0] = {3{top}};
                snap_next[1] = {3{mid}};
                snap_next[2] = {3{bot}};
            end
            else
            begin
                snap_next = shifted;
            end
            dbl_next = double_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_reg <= '0;
            dbl_reg  <= 1'b0;
        end
        else
        begin
            snap_reg <= snap_next;
            dbl_reg  <= dbl_next;
        end
    end

    assign grad_a = sg3_gradient(snap_reg);
    assign grad_b = sg3_gradient(sg3_shift(snap_reg));

endmodule

// File: src/sg3_out_fifo.sv
// Result queue that takes up to two entries per cycle and gives one.
// Depends on sg3_pkg for the result type and queue depth.
`timescale 1ns / 1ps

module sg3_out_fifo
    import sg3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_cnt,
    input  sg3_res_t              push_data0,
    input  sg3_res_t              push_data1,
    input  logic                  pop,
    output logic                  not_empty,
    output sg3_res_t              head,
    output logic [FIFO_CNT_W-1:0] count
);

    sg3_res_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(do_pop);
        count_next  = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/sobel_gradient_3x3.sv
// Top level of the 3x3 Sobel gradient block: counters, line store, window, queue.
// Depends on sg3_pkg, sg3_line_store, sg3_window, sg3_out_fifo and the macros header.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one transaction per raster pixel (tuser = 0) with the grey value
//   in tdata; after the frame's last pixel, send frame_width drain transactions
//   (tuser = 1) to flush the bottom row. Out-of-place transactions (a pixel past
//   the last row, a drain before it) are taken and dropped.
//   Master stream: one transaction per output pixel in raster order, tdata holds
//   grad_x and grad_y, tlast marks the last result of an input transaction and
//   tuser marks the frame's bottom right result. A result lags its pixel by one
//   row and one column; the last pixel of any row but the first gives two results.
//   Throughput: one input transaction per cycle while tready is high. Results
//   pass the stage 1 and stage 2 registers into the output queue and leave it
//   in order on the master side.
//   Stalls: the 8-entry output queue decouples the sides; tready drops only when
//   the queue, counting room for the items still in the two stages, could not
//   take two more results.
//   Reset: counters, window and queue clear; frame_width returns to 640 and
//   frame_height to 480. Write the registers only while the block is idle.
module sobel_gradient_3x3
    import sg3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] pixel
    input  logic                 s_axis_tuser,   // [0] cmd
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [10:0] grad_x, [21:11] grad_y, rest zero
    output logic                 m_axis_tlast,   // run_end
    output logic                 m_axis_tuser    // [0] frame_end
);

`include "sobel_gradient_3x3_macros.svh"

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (sg3_cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // ---------------- input stage: decode, counters ----------------
    logic [ADDR_W-1:0] column_count_reg;
    logic [ADDR_W-1:0] column_count_next;
    logic [CFG_W-1:0]  row_count_reg;
    logic [CFG_W-1:0]  row_count_next;
    logic [ADDR_W-1:0] drain_count_reg;
    logic [ADDR_W-1:0] drain_count_next;

    logic [CFG_W-1:0]  width_eff;
    logic [CFG_W-1:0]  height_eff;
    logic              in_cmd;
    sg3_pix_t          in_pix;
    logic [ADDR_W-1:0] in_col;
    logic              in_ok;
    logic              in_last;
    logic              accept;
    logic              advance;

    assign in_cmd = s_axis_tuser;
    assign in_pix = s_axis_tdata[PIX_W-1:0];
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        // clamp the registers to the usable range
        if (frame_width_reg == '0)
        begin
            width_eff = CFG_W'(1);
        end
        else if (frame_width_reg > CFG_W'(MAX_WIDTH))
        begin
            width_eff = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = frame_width_reg;
        end
        height_eff = (frame_height_reg == '0) ? CFG_W'(1) : frame_height_reg;

        in_col  = in_cmd ? drain_count_reg : column_count_reg;
        in_ok   = in_cmd ? (row_count_reg >= height_eff) : (row_count_reg < height_eff);
        // a column at or past the width counts as the last one
        in_last = (CFG_W'(in_col) + CFG_W'(1)) >= width_eff;
    end

    assign advance = accept && in_ok;

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        drain_count_next  = drain_count_reg;
        if (advance)
        begin
            if (!in_cmd)
            begin
                if (in_last)
                begin
                    column_count_next = '0;
                    if (row_count_reg != '1)
                    begin
                        row_count_next = row_count_reg + CFG_W'(1);
                    end
                end
                else
                begin
                    column_count_next = column_count_reg + ADDR_W'(1);
                end
            end
            else
            begin
                if (in_last)
                begin
                    // frame done: clear for the next frame
                    drain_count_next  = '0;
                    row_count_next    = '0;
                    column_count_next = '0;
                end
                else
                begin
                    drain_count_next = drain_count_reg + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            drain_count_reg  <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            drain_count_reg  <= drain_count_next;
        end
    end

    // ---------------- stage 1 registers: line store read in flight ----------------
    logic              s1_valid_reg;
    sg3_ctl_t          s1_ctl_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    sg3_pix_t          s1_pix_reg;
    logic              fwd_hit_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    logic              ls_we;
    logic [LINE_W-1:0] ls_wdata;
    logic [LINE_W-1:0] ls_rdata;
    logic [LINE_W-1:0] line_word;
    sg3_pix_t          line_top;
    sg3_pix_t          line_mid;
    sg3_pix_t          line_bot;

    assign ls_we = s1_valid_reg && !s1_ctl_reg.cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= advance;
        end
    end

    // Payload: hold the item and catch a write to the address being read
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg.cmd      <= in_cmd;
            s1_ctl_reg.col_zero <= (in_col == '0);
            s1_ctl_reg.last     <= in_last;
            s1_ctl_reg.active   <= in_cmd || (row_count_reg != '0);
            s1_ctl_reg.row0     <= (row_count_reg == '0);
            s1_addr_reg         <= in_col;
            s1_pix_reg          <= in_pix;
            fwd_hit_reg         <= ls_we && (s1_addr_reg == in_col);
            fwd_data_reg        <= ls_wdata;
        end
    end

    sg3_line_store u_line_store (
        .clk     (clk),
        .wr_en   (ls_we),
        .wr_addr (s1_addr_reg),
        .wr_data (ls_wdata),
        .rd_en   (advance),
        .rd_addr (in_col),
        .rd_data (ls_rdata)
    );

    always_comb
    begin
        line_word = fwd_hit_reg ? fwd_data_reg : ls_rdata;
        line_top  = line_word[LINE_W-1:PIX_W];
        line_mid  = line_word[PIX_W-1:0];
        // drain: the middle row stands in for the missing row below
        line_bot  = s1_ctl_reg.cmd ? line_mid : s1_pix_reg;
        // first row seeds both stored rows, later rows move up by one
        ls_wdata  = {(s1_ctl_reg.row0 ? s1_pix_reg : line_mid), s1_pix_reg};
    end

    // ---------------- window and gradients ----------------
    sg3_grad_t grad_a;
    sg3_grad_t grad_b;

    sg3_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (s1_valid_reg),
        .col_zero     (s1_ctl_reg.col_zero),
        .double_shift (s1_ctl_reg.active && s1_ctl_reg.last),
        .top          (line_top),
        .mid          (line_mid),
        .bot          (line_bot),
        .grad_a       (grad_a),
        .grad_b       (grad_b)
    );

    // ---------------- stage 2: push results ----------------
    logic      s2_valid_reg;
    sg3_emit_t s2_emit_reg;
    logic [1:0] push_cnt;
    sg3_res_t  res_a;
    sg3_res_t  res_b;
    sg3_res_t  push_data0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_emit_reg  <= '0;
        end
        else
        begin
            s2_valid_reg          <= s1_valid_reg;
            s2_emit_reg.emit_a    <= s1_valid_reg && s1_ctl_reg.active && !s1_ctl_reg.col_zero;
            s2_emit_reg.emit_b    <= s1_valid_reg && s1_ctl_reg.active && s1_ctl_reg.last;
            s2_emit_reg.frame_end <= s1_ctl_reg.cmd;
        end
    end

    always_comb
    begin
        res_a.grad      = grad_a;
        res_a.frame_end = 1'b0;
        res_a.run_end   = !s2_emit_reg.emit_b;
        // the extra result of a row end repeats the last column
        res_b.grad      = grad_b;
        res_b.frame_end = s2_emit_reg.frame_end;
        res_b.run_end   = 1'b1;
        push_data0      = s2_emit_reg.emit_a ? res_a : res_b;
        push_cnt        = s2_valid_reg
                        ? (2'(s2_emit_reg.emit_a) + 2'(s2_emit_reg.emit_b)) : 2'd0;
    end

    sg3_res_t              head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FILL_W-1:0]     fill_bound;

    sg3_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_data0 (push_data0),
        .push_data1 (res_b),
        .pop        (m_axis_tready),
        .not_empty  (m_axis_tvalid),
        .head       (head),
        .count      (fifo_count)
    );

    // Reserve two entries for each item in flight plus the one being offered
    assign fill_bound = FILL_W'(fifo_count) + FILL_W'({s1_valid_reg, 1'b0})
                      + FILL_W'({s2_valid_reg, 1'b0});
    assign s_axis_tready = (fill_bound <= FILL_W'(FIFO_DEPTH - 2));

    assign m_axis_tdata = {{(M_TDATA_W - 2 * GRAD_W){1'b0}}, head.grad.gy, head.grad.gx};
    assign m_axis_tlast = head.run_end;
    assign m_axis_tuser = head.frame_end;

    // ---------------- assertions ----------------
    `SG3_ASSERT_NOW(a_fifo_room, s2_valid_reg,
        (FILL_W'(fifo_count) + FILL_W'(push_cnt)) <= FILL_W'(FIFO_DEPTH),
        "result queue overflow")
    `SG3_ASSERT_NEXT(a_ignored_dropped, accept && !in_ok, !s1_valid_reg,
        "out-of-place transaction entered the window stage")
    `SG3_ASSERT_NEXT(a_row_wrap, advance && !in_cmd && in_last, column_count_reg == '0,
        "column count did not wrap at row end")
    `SG3_ASSERT_NEXT(a_drain_clear, advance && in_cmd && in_last,
        (row_count_reg == '0) && (drain_count_reg == '0) && (column_count_reg == '0),
        "counters not cleared at frame end")

endmodule
